// ----- rtl/ptw_pkg.sv -----
// Shared types and constants of the page-table walker.
// Used by the channel interfaces and by the walker top level; depends on nothing.

package ptw_pkg;

	localparam int VA_W     = 48;
	localparam int PA_W     = 52;
	localparam int ENTRY_W  = 64;
	localparam int FRAME_W  = 40;
	localparam int IDX_W    = 9;
	localparam int PAGE_SHIFT = 12;
	localparam int STATUS_W = 2;

	localparam logic [FRAME_W-1:0] BASE_FRAME_RESET = 40'd256;
	localparam logic [ENTRY_W-1:0] ADDR_FIELD_MASK  = 64'h000F_FFFF_FFFF_F000;
	localparam logic [ENTRY_W-1:0] FLAGS_PRESENT_RW = 64'h0000_0000_0000_0003;

	localparam logic FUNC_MAP    = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_PATH  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_TABLE = 2'd2;

	localparam logic REG_TABLE_BASE_FRAME = 1'b0;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_PUT
	} walk_state_t;

	// Replaces the frame field and sets present and read-write.
	function automatic logic [ENTRY_W-1:0] rewrite_entry(
		input logic [ENTRY_W-1:0] old_entry,
		input logic [FRAME_W-1:0] frame
	);
		logic [ENTRY_W-1:0] frame_field;
		frame_field = {12'd0, frame, 12'd0};
		return (old_entry & ~ADDR_FIELD_MASK) | frame_field | FLAGS_PRESENT_RW;
	endfunction

endpackage

// ----- rtl/ptw_if.sv -----
// Request and response channel interfaces of the page-table walker.
// Depends on ptw_pkg for the field widths.

interface ptw_req_if import ptw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [VA_W-1:0]      virt_addr;
	logic [PA_W-1:0]      physical_address;

	modport source (output valid, output func, output virt_addr,
		output physical_address, input ready);
	modport sink (input valid, input func, input virt_addr,
		input physical_address, output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [ENTRY_W-1:0]   leaf_entry;

	modport source (output valid, output status, output leaf_entry, input ready);
	modport sink (input valid, input status, input leaf_entry, output ready);
endinterface

// ----- rtl/page_table_walker_map_lookup_top.sv -----
// Four-level page-table walker with an internal table store and bump allocator.
// Depends on ptw_pkg and on the channel interfaces in ptw_if.sv.
//
// After reset the block clears its table store, one entry per cycle, through
// all NUM_TABLES*512 entries (32768 at the default), and takes no request until
// that pass is done; the configuration port works throughout. A request is then
// taken in from the idle state; each level visited passes through a read of the
// table store and an evaluate state that may write back the entry; and the put
// state loads the response register once it is empty or being read. A walk
// ends early when a lookup finds no path or a map runs out of tables. The
// next request is taken while the previous response still waits.

module page_table_walker_map_lookup_top
	import ptw_pkg::*;
#(
	parameter int NUM_TABLES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	ptw_req_if.sink             req,
	ptw_rsp_if.source           rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);

	localparam int TW    = $clog2(NUM_TABLES);
	localparam int AW    = TW + IDX_W;
	localparam int DEPTH = NUM_TABLES * 512;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [ENTRY_W-1:0] mem [DEPTH];

	walk_state_t        state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [1:0]         level_q;
	logic [TW-1:0]      table_q;
	logic [TW:0]        next_free_q;
	logic [FRAME_W-1:0] base_q;
	logic               out_valid_q;

	logic               func_q;
	logic [VA_W-1:0]    va_q;
	logic [FRAME_W-1:0] pa_frame_q;
	logic [ENTRY_W-1:0] rdata_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ENTRY_W-1:0] res_leaf_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ENTRY_W-1:0] out_leaf_q;

	logic [IDX_W-1:0]   idx;
	logic [AW-1:0]      walk_addr;
	logic [FRAME_W-1:0] entry_frame;
	logic [FRAME_W-1:0] frame_off;
	logic               follow_ok;
	logic               tables_full;
	logic [FRAME_W-1:0] new_frame;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               out_load;
	logic               cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[3] == REG_TABLE_BASE_FRAME);
	assign prdata    = (paddr[3] == REG_TABLE_BASE_FRAME) ? {24'd0, base_q} : 64'd0;

	always_comb begin
		case (level_q)
			2'd0: idx = va_q[47:39];
			2'd1: idx = va_q[38:30];
			2'd2: idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	assign walk_addr   = {table_q, idx};
	assign entry_frame = rdata_q[51:12];
	assign frame_off   = entry_frame - base_q;
	assign follow_ok   = rdata_q[0] && (frame_off < FRAME_W'(NUM_TABLES));
	assign tables_full = next_free_q >= (TW+1)'(NUM_TABLES);
	assign new_frame   = base_q + FRAME_W'(next_free_q);
	assign out_load    = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = walk_addr;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (level_q != 2'd3) begin
					if (follow_ok) begin
						state_d = S_READ;
					end else if (func_q == FUNC_LOOKUP || tables_full) begin
						state_d = S_PUT;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = rewrite_entry(rdata_q, new_frame);
						state_d   = S_READ;
					end
				end else begin
					mem_we    = (func_q == FUNC_MAP);
					mem_wdata = rewrite_entry(rdata_q, pa_frame_q);
					state_d   = S_PUT;
				end
			end
			S_PUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			level_q     <= '0;
			table_q     <= '0;
			next_free_q <= (TW+1)'(1);
			base_q      <= BASE_FRAME_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				base_q <= pwdata[FRAME_W-1:0];
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_IDLE && req.valid) begin
				level_q <= '0;
				table_q <= '0;
			end
			if (state_q == S_EVAL && level_q != 2'd3) begin
				if (follow_ok) begin
					table_q <= frame_off[TW-1:0];
					level_q <= level_q + 2'd1;
				end else if (func_q == FUNC_MAP && !tables_full) begin
					table_q     <= next_free_q[TW-1:0];
					next_free_q <= next_free_q + (TW+1)'(1);
					level_q     <= level_q + 2'd1;
				end
			end
			if (state_q == S_PUT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			func_q     <= req.func;
			va_q       <= req.virt_addr;
			pa_frame_q <= req.physical_address[PA_W-1:PAGE_SHIFT];
		end
		if (state_q == S_EVAL) begin
			if (level_q == 2'd3) begin
				res_status_q <= STATUS_OK;
				res_leaf_q   <= (func_q == FUNC_MAP) ? mem_wdata : rdata_q;
			end else if (!follow_ok && func_q == FUNC_LOOKUP) begin
				res_status_q <= STATUS_NO_PATH;
				res_leaf_q   <= '0;
			end else if (!follow_ok && tables_full) begin
				res_status_q <= STATUS_NO_TABLE;
				res_leaf_q   <= '0;
			end
		end
		if (state_q == S_PUT && out_load) begin
			out_status_q <= res_status_q;
			out_leaf_q   <= res_leaf_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[walk_addr];
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.leaf_entry = out_leaf_q;

	a_free_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q >= (TW+1)'(1) && next_free_q <= (TW+1)'(NUM_TABLES))
		else $error("Allocator index left its range.");

	a_free_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q >= $past(next_free_q))
		else $error("Allocator index went backward.");

	a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req.ready)
		else $error("Request taken during the clearing pass.");

	a_error_leaf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STATUS_OK) |-> rsp.leaf_entry == '0)
		else $error("Error response carries a nonzero leaf entry.");

	a_alloc_only_map: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != $past(next_free_q)) |-> $past(func_q == FUNC_MAP && state_q == S_EVAL))
		else $error("Table allocated outside a map walk.");

endmodule
